>>> design/stereo_to_2_1_upmix_lowpass_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stereo to 2.1 upmix core
// Shared property wrappers used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef STEREO_TO_2_1_UPMIX_LOWPASS_CORE_MACROS_SVH
`define STEREO_TO_2_1_UPMIX_LOWPASS_CORE_MACROS_SVH

// Clocked property, switched off while reset is asserted
`define S21U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked property that also holds across reset
`define S21U_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/s21u_pkg.sv
// ----------------------------------------------------------------------------
// s21u_pkg
// Constants and types shared by the stereo to 2.1 upmix core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package s21u_pkg;

  // Fixed-point format of the filter coefficient and state
  localparam int FRAC_BITS = 16;
  localparam int HALF_Q16  = 32768;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_LOWPASS_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING_FACTOR = 2'd1;

  localparam logic [CFG_DATA_W-1:0] SMOOTHING_RESET = 17'h10000;

  // Channel tags carried on the result channel
  localparam int TAG_W = 2;
  localparam logic [TAG_W-1:0] TAG_LEFT  = 2'd0;
  localparam logic [TAG_W-1:0] TAG_RIGHT = 2'd1;
  localparam logic [TAG_W-1:0] TAG_SUB   = 2'd2;

  // Position of the serialiser within a frame
  typedef enum logic [1:0] {
    PH_LEFT,
    PH_RIGHT,
    PH_SUB
  } phase_t;

endpackage

>>> design/stereo_to_2_1_upmix_lowpass_core.sv
// ----------------------------------------------------------------------------
// stereo_to_2_1_upmix_lowpass_core
// Stereo to 2.1 upmixer with an optional one-pole low-pass on the sub channel.
// ----------------------------------------------------------------------------
// Each accepted stereo frame yields three results in order: left (tag 0),
// right (tag 1) and the subwoofer sample (tag 2, tlast high). The sub sample is
// the average of left and right truncated toward zero, or, with the low-pass
// on, the Q16.16 filter state rounded half away from zero and clamped. A frame
// is accepted in any cycle the input register is free; the single result
// channel gives one result a cycle while out_tready is high, so a frame takes
// three result transfers. A frame passes the input register and then the
// result register; the next frame may wait in the input register meanwhile.
// The filter update runs in one pass between the two registers. Configuration
// writes are always accepted and are meant to be made while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module stereo_to_2_1_upmix_lowpass_core #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // in_tdata: left_sample, right_sample
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  // out_tdata: out_sample
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]         out_tdata,
  // out_tuser: channel_tag
  output logic [s21u_pkg::TAG_W-1:0]                out_tuser,
  output logic                                      out_tlast,
  input  logic                                      cfg_valid,
  output logic                                      cfg_ready,
  input  logic [s21u_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [s21u_pkg::CFG_DATA_W-1:0]           cfg_data
);

  localparam int SW     = SAMPLE_WIDTH;
  localparam int OUT_DW = ((SAMPLE_WIDTH + 7) / 8) * 8;

  logic                                 lowpass_enable_r;
  logic                                 lowpass_enable_nxt;
  logic [s21u_pkg::CFG_DATA_W-1:0]      smoothing_factor_r;
  logic [s21u_pkg::CFG_DATA_W-1:0]      smoothing_factor_nxt;

  logic                                 in_valid_r;
  logic                                 in_valid_nxt;
  logic signed [SW-1:0]                 left_r;
  logic signed [SW-1:0]                 right_r;

  logic                                 load_ready;
  logic                                 load;
  logic signed [SW-1:0]                 sub_sample;
  logic signed [SW-1:0]                 res_sample;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_comb begin
    lowpass_enable_nxt   = lowpass_enable_r;
    smoothing_factor_nxt = smoothing_factor_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        s21u_pkg::CFG_LOWPASS_ENABLE:   lowpass_enable_nxt   = cfg_data[0];
        s21u_pkg::CFG_SMOOTHING_FACTOR: smoothing_factor_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lowpass_enable_r   <= 1'b0;
      smoothing_factor_r <= s21u_pkg::SMOOTHING_RESET;
    end else begin
      lowpass_enable_r   <= lowpass_enable_nxt;
      smoothing_factor_r <= smoothing_factor_nxt;
    end
  end

  // Input register: free when empty or when its frame moves on this cycle
  assign load      = in_valid_r && load_ready;
  assign in_tready = !in_valid_r || load_ready;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_tvalid && in_tready) begin
      in_valid_nxt = 1'b1;
    end else if (load) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      left_r  <= in_tdata[SW-1:0];
      right_r <= in_tdata[2*SW-1:SW];
    end
  end

  // Sub channel and filter state
  s21u_filter #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_filter (
    .clk             (clk),
    .rst_n           (rst_n),
    .left_sample     (left_r),
    .right_sample    (right_r),
    .lowpass_enable  (lowpass_enable_r),
    .smoothing_factor(smoothing_factor_r),
    .update          (load),
    .sub_sample      (sub_sample)
  );

  // Result register and serialiser
  s21u_serial #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_serial (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_valid  (in_valid_r),
    .load_ready  (load_ready),
    .left_sample (left_r),
    .right_sample(right_r),
    .sub_sample  (sub_sample),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_sample  (res_sample),
    .res_tag     (out_tuser),
    .res_last    (out_tlast)
  );

  assign out_tdata = OUT_DW'($unsigned(res_sample));

endmodule

>>> design/s21u_filter.sv
// ----------------------------------------------------------------------------
// s21u_filter
// Sub channel: average of left and right, optionally through a one-pole
// low-pass held in a Q16.16 state register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s21u_filter #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic signed [SAMPLE_WIDTH-1:0]       left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]       right_sample,
  input  logic                                 lowpass_enable,
  input  logic [s21u_pkg::CFG_DATA_W-1:0]      smoothing_factor,
  input  logic                                 update,
  output logic signed [SAMPLE_WIDTH-1:0]       sub_sample
);

  localparam int SW  = SAMPLE_WIDTH;
  localparam int FB  = s21u_pkg::FRAC_BITS;
  localparam int STW = SW + FB + 1;   // state width
  localparam int DW  = STW + 1;       // difference width
  localparam int PW  = DW + FB + 1;   // product width
  localparam int QW  = STW + 1 - FB;  // rounded magnitude width
  localparam int RW  = QW + 1;        // rounded signed width

  localparam logic signed [RW-1:0] SAMPLE_MAX = RW'((64'sd1 <<< (SW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAMPLE_MIN = RW'(-(64'sd1 <<< (SW - 1)));

  logic signed [STW-1:0] filter_state_r;
  logic signed [STW-1:0] filter_state_nxt;

  logic signed [SW:0]    sum;
  logic signed [SW:0]    sum_adj;
  logic signed [SW-1:0]  avg;
  logic signed [DW-1:0]  target;
  logic signed [DW-1:0]  state_ext;
  logic signed [DW-1:0]  diff;
  logic signed [PW-1:0]  prod;
  logic signed [DW-1:0]  inc;
  logic signed [DW-1:0]  state_sum;
  logic signed [STW-1:0] state_upd;
  logic                  upd_neg;
  logic [STW-1:0]        upd_mag;
  logic [STW:0]          mag_rnd;
  logic [QW-1:0]         mag_q;
  logic signed [RW-1:0]  rounded;
  logic signed [SW-1:0]  clamped;

  // Average truncated toward zero: bias negative sums by one before halving
  assign sum     = {left_sample[SW-1], left_sample} + {right_sample[SW-1], right_sample};
  assign sum_adj = sum + {{SW{1'b0}}, sum[SW]};
  assign avg     = sum_adj[SW:1];

  // Difference between target and state, both Q16.16
  assign target    = {{(DW - SW - FB){avg[SW-1]}}, avg, {FB{1'b0}}};
  assign state_ext = {filter_state_r[STW-1], filter_state_r};
  assign diff      = target - state_ext;

  // Scale by alpha; an alpha of one or more passes the difference whole
  assign prod = diff * $signed({1'b0, smoothing_factor[FB-1:0]});
  assign inc  = smoothing_factor[FB] ? diff : prod[DW+FB-1:FB];

  assign state_sum = state_ext + inc;
  assign state_upd = state_sum[STW-1:0];

  // Round half away from zero on the magnitude
  assign upd_neg = state_upd[STW-1];
  assign upd_mag = upd_neg ? STW'(-state_upd) : STW'(state_upd);
  assign mag_rnd = {1'b0, upd_mag} + (STW+1)'(s21u_pkg::HALF_Q16);
  assign mag_q   = mag_rnd[STW:FB];
  assign rounded = upd_neg ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_q});

  // Clamp to the sample range
  always_comb begin
    if (rounded > SAMPLE_MAX) begin
      clamped = SAMPLE_MAX[SW-1:0];
    end else if (rounded < SAMPLE_MIN) begin
      clamped = SAMPLE_MIN[SW-1:0];
    end else begin
      clamped = rounded[SW-1:0];
    end
  end

  assign sub_sample = lowpass_enable ? clamped : avg;

  // Advance the state only when a frame is taken with the filter on
  always_comb begin
    filter_state_nxt = filter_state_r;
    if (update && lowpass_enable) begin
      filter_state_nxt = state_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_state_r <= '0;
    end else begin
      filter_state_r <= filter_state_nxt;
    end
  end

endmodule

>>> design/s21u_serial.sv
// ----------------------------------------------------------------------------
// s21u_serial
// Result register: holds one frame and hands out left, right and sub in turn.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module s21u_serial #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              load_valid,
  output logic                              load_ready,
  input  logic signed [SAMPLE_WIDTH-1:0]    left_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    right_sample,
  input  logic signed [SAMPLE_WIDTH-1:0]    sub_sample,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic signed [SAMPLE_WIDTH-1:0]    res_sample,
  output logic [s21u_pkg::TAG_W-1:0]        res_tag,
  output logic                              res_last
);

  s21u_pkg::phase_t phase_r;
  s21u_pkg::phase_t phase_nxt;
  logic             valid_r;
  logic             valid_nxt;

  logic signed [SAMPLE_WIDTH-1:0] left_r;
  logic signed [SAMPLE_WIDTH-1:0] right_r;
  logic signed [SAMPLE_WIDTH-1:0] sub_r;

  logic take;
  logic load;

  assign take       = valid_r && res_ready;
  assign load_ready = !valid_r || (take && (phase_r == s21u_pkg::PH_SUB));
  assign load       = load_valid && load_ready;

  // Next state: load a fresh frame or step through the current one
  always_comb begin
    phase_nxt = phase_r;
    valid_nxt = valid_r;
    if (load) begin
      phase_nxt = s21u_pkg::PH_LEFT;
      valid_nxt = 1'b1;
    end else if (take) begin
      unique case (phase_r)
        s21u_pkg::PH_LEFT:  phase_nxt = s21u_pkg::PH_RIGHT;
        s21u_pkg::PH_RIGHT: phase_nxt = s21u_pkg::PH_SUB;
        s21u_pkg::PH_SUB:   valid_nxt = 1'b0;
        default:            valid_nxt = 1'b0;
      endcase
    end
  end

  // Outputs: select the sample and tag for the current position
  always_comb begin
    unique case (phase_r)
      s21u_pkg::PH_LEFT: begin
        res_sample = left_r;
        res_tag    = s21u_pkg::TAG_LEFT;
        res_last   = 1'b0;
      end
      s21u_pkg::PH_RIGHT: begin
        res_sample = right_r;
        res_tag    = s21u_pkg::TAG_RIGHT;
        res_last   = 1'b0;
      end
      s21u_pkg::PH_SUB: begin
        res_sample = sub_r;
        res_tag    = s21u_pkg::TAG_SUB;
        res_last   = 1'b1;
      end
      default: begin
        res_sample = sub_r;
        res_tag    = s21u_pkg::TAG_SUB;
        res_last   = 1'b1;
      end
    endcase
  end

  assign res_valid = valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= s21u_pkg::PH_LEFT;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
  end

  // Capture the frame payload
  always_ff @(posedge clk) begin
    if (load) begin
      left_r  <= left_sample;
      right_r <= right_sample;
      sub_r   <= sub_sample;
    end
  end

endmodule

>>> design/s21u_checker.sv
// ----------------------------------------------------------------------------
// s21u_checker
// Port-level checks on the result channel of the upmix core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stereo_to_2_1_upmix_lowpass_core_macros.svh"

module s21u_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]    out_tdata,
  input logic [s21u_pkg::TAG_W-1:0]           out_tuser,
  input logic                                 out_tlast
);

  // A stalled result holds
  `S21U_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

  // tlast marks the sub result and nothing else
  `S21U_ASSERT(a_last_is_sub, out_tvalid |-> (out_tlast == (out_tuser == s21u_pkg::TAG_SUB)), "tlast and channel tag disagree")

  // Left is always followed by right within a frame
  `S21U_ASSERT(a_left_then_right, out_tvalid && out_tready && (out_tuser == s21u_pkg::TAG_LEFT) |=> out_tvalid && (out_tuser == s21u_pkg::TAG_RIGHT), "right result missing after left")

  // A new frame always opens with left
  `S21U_ASSERT(a_sub_then_left, out_tvalid && out_tready && out_tlast |=> !out_tvalid || (out_tuser == s21u_pkg::TAG_LEFT), "frame did not start with left")

  // No result straight after reset
  `S21U_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind stereo_to_2_1_upmix_lowpass_core s21u_checker #(
  .SAMPLE_WIDTH(SAMPLE_WIDTH)
) u_s21u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

>>> bench/tb_stereo_to_2_1_upmix_lowpass_core.sv
// ----------------------------------------------------------------------------
// tb_stereo_to_2_1_upmix_lowpass_core
// Self-checking bench for the stereo to 2.1 upmix core with sub low-pass.
// ----------------------------------------------------------------------------
// Stereo frames go in on the input stream. Each accepted frame is run through
// a local model of the upmix and the one-pole filter, which queues the left,
// right and sub results it should produce. A checker pops one expectation per
// result transaction and compares sample, channel tag and tlast. Directed
// frames cover the sample extremes, rounding of the average, coefficients of
// zero, one, the minimum and above one, and writes to unused register
// indexes. Random phases then change the configuration while the core is
// idle, with random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stereo_to_2_1_upmix_lowpass_core;

  localparam int SAMPLE_W      = 16;
  localparam int IN_W          = ((2*SAMPLE_W+7)/8)*8;
  localparam int OUT_W         = ((SAMPLE_W+7)/8)*8;
  localparam int SETTLE_CYCLES = 8;
  localparam int IDLE_LIMIT    = 2000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_FRAMES  = 27;

  localparam longint Q16_ONE = 65536;
  localparam longint Q16_HALF = 32768;
  localparam longint SAMPLE_MAX = 32767;
  localparam longint SAMPLE_MIN = -32768;

  // Register indexes the core does not decode
  localparam logic [s21u_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [s21u_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0]     sample;
    logic [s21u_pkg::TAG_W-1:0]     tag;
    logic                           last;
  } upmix_result_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [IN_W-1:0]                     in_tdata = '0;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic [OUT_W-1:0]                    out_tdata;
  logic [s21u_pkg::TAG_W-1:0]          out_tuser;
  logic                                out_tlast;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [s21u_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
  logic [s21u_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

  // Local copy of the filter configuration and state
  logic                                lp_enable = 1'b0;
  logic [s21u_pkg::CFG_DATA_W-1:0]     lp_alpha = s21u_pkg::SMOOTHING_RESET;
  longint                              filt_state = 0;

  upmix_result_t          upmix_expected[$];
  int                     mismatch_count = 0;
  int                     burst_left = 0;
  int                     idle_cycles = 0;
  bit                     gaps_on = 1'b0;
  bit                     stalls_on = 1'b0;
  int                     stall_run = 0;

  stereo_to_2_1_upmix_lowpass_core #(
    .SAMPLE_WIDTH(SAMPLE_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the three results of one frame and advance the filter
  function automatic void predict_upmix(input logic signed [SAMPLE_W-1:0] left,
                                        input logic signed [SAMPLE_W-1:0] right);
    longint avg;
    longint alpha;
    longint diff;
    longint rounded;
    upmix_result_t res;
    avg = (longint'(left) + longint'(right)) / 2;
    if (lp_enable) begin
      alpha = (lp_alpha > Q16_ONE) ? Q16_ONE : longint'(lp_alpha);
      diff = avg * Q16_ONE - filt_state;
      filt_state = filt_state + ((alpha * diff) >>> 16);
      if (filt_state >= 0)
        rounded = (filt_state + Q16_HALF) >>> 16;
      else
        rounded = -((Q16_HALF - filt_state) >>> 16);
      if (rounded > SAMPLE_MAX)
        avg = SAMPLE_MAX;
      else if (rounded < SAMPLE_MIN)
        avg = SAMPLE_MIN;
      else
        avg = rounded;
    end
    res = '{sample: left, tag: s21u_pkg::TAG_LEFT, last: 1'b0};
    upmix_expected = {upmix_expected, res};
    res = '{sample: right, tag: s21u_pkg::TAG_RIGHT, last: 1'b0};
    upmix_expected = {upmix_expected, res};
    res = '{sample: avg[SAMPLE_W-1:0], tag: s21u_pkg::TAG_SUB, last: 1'b1};
    upmix_expected = {upmix_expected, res};
  endfunction

  // Track register writes and frames, and check every result transaction
  always @(posedge clk) begin : result_check
    upmix_result_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          s21u_pkg::CFG_LOWPASS_ENABLE:   lp_enable = cfg_data[0];
          s21u_pkg::CFG_SMOOTHING_FACTOR: lp_alpha = cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predict_upmix(in_tdata[SAMPLE_W-1:0], in_tdata[2*SAMPLE_W-1:SAMPLE_W]);
      if (out_tvalid && out_tready) begin
        if (upmix_expected.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sample %0d tag %0d last %0b",
                   $time, $signed(out_tdata[SAMPLE_W-1:0]), out_tuser, out_tlast);
          mismatch_count++;
        end else begin
          want = upmix_expected.pop_front();
          if (out_tdata[SAMPLE_W-1:0] !== want.sample) begin
            $display("%0t: out_sample mismatch, expected %0d, got %0d", $time,
                     $signed(want.sample), $signed(out_tdata[SAMPLE_W-1:0]));
            mismatch_count++;
          end
          if (out_tuser !== want.tag) begin
            $display("%0t: channel_tag mismatch, expected %0d, got %0d", $time,
                     want.tag, out_tuser);
            mismatch_count++;
          end
          if (out_tlast !== want.last) begin
            $display("%0t: last_of_frame mismatch, expected %0b, got %0b", $time,
                     want.last, out_tlast);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stall the result channel in runs of random length
  always @(posedge clk) begin
    if (!stalls_on) begin
      out_tready <= 1'b1;
      stall_run = 0;
    end else if (stall_run > 0) begin
      stall_run--;
    end else begin
      out_tready <= !out_tready;
      stall_run = out_tready ? $urandom_range(0, 5) : $urandom_range(0, 8);
    end
  end

  // End the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("tb_stereo_to_2_1_upmix_lowpass_core failed");
        $finish;
      end
    end
  end

  // Offer one frame, with a random gap at the start of each burst when gaps are on
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {right, left};
    do @(posedge clk); while (!in_tready);
    if (burst_left > 0)
      burst_left--;
  endtask

  // Write one register; hold keeps valid high for a following write
  task automatic write_reg(input logic [s21u_pkg::CFG_IDX_W-1:0] idx,
                           input logic [s21u_pkg::CFG_DATA_W-1:0] value, input bit hold);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (!hold)
      cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic enable,
                           input logic [s21u_pkg::CFG_DATA_W-1:0] alpha);
    write_reg(s21u_pkg::CFG_LOWPASS_ENABLE, {{(s21u_pkg::CFG_DATA_W-1){1'b0}}, enable}, 1'b1);
    write_reg(s21u_pkg::CFG_SMOOTHING_FACTOR, alpha, 1'b0);
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (upmix_expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      1: return SAMPLE_W'($signed($urandom_range(0, 16)) - 8);
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  function automatic logic [s21u_pkg::CFG_DATA_W-1:0] pick_alpha();
    case ($urandom_range(0, 7))
      0: return 17'd1;
      1: return 17'h10000;
      2: return 17'h1ffff;
      3: return 17'd0;
      4: return s21u_pkg::CFG_DATA_W'($urandom_range(1, 4096));
      5: return s21u_pkg::CFG_DATA_W'($urandom_range(65537, 131071));
      default: return s21u_pkg::CFG_DATA_W'($urandom_range(1, 65536));
    endcase
  endfunction

  // Reset values: low-pass off, sub is the truncated average
  task automatic test_reset_passthrough();
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7fff, 16'sh8000);
    send_frame(16'sh8000, 16'sh7fff);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(-16'sd1, 16'sd0);
    send_frame(-16'sd3, 16'sd0);
    send_frame(16'sd1, 16'sd2);
    send_frame(16'sh5555, 16'shaaaa);
    wait_drained();
  endtask

  // Coefficient of one: the filter tracks the average exactly
  task automatic test_alpha_one();
    configure(1'b1, 17'h10000);
    send_frame(16'sh7fff, 16'sh7ffe);
    send_frame(16'sh8000, 16'sh8001);
    send_frame(-16'sd5, 16'sd2);
    wait_drained();
  endtask

  // Coefficients above one act as one
  task automatic test_alpha_above_one();
    configure(1'b1, 17'h1ffff);
    send_frame(16'sd1234, -16'sd4321);
    send_frame(16'sh8000, 16'sh8000);
    wait_drained();
    configure(1'b1, 17'h10001);
    send_frame(16'sh7fff, 16'sh7fff);
    wait_drained();
  endtask

  // Coefficient of zero: the state holds and the sub sample repeats
  task automatic test_alpha_zero();
    configure(1'b1, 17'd0);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sd0, 16'sd0);
    wait_drained();
  endtask

  // Writes to unused indexes must leave both registers alone
  task automatic test_unused_index();
    write_reg(CFG_IDX_SPARE_A, 17'h1ffff, 1'b1);
    write_reg(CFG_IDX_SPARE_B, 17'h00000, 1'b0);
    send_frame(16'sh7fff, 16'sh0001);
    send_frame(-16'sd77, 16'sd99);
    wait_drained();
  endtask

  // Smallest coefficient: slow creep from full scale
  task automatic test_alpha_min();
    configure(1'b1, 17'd1);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7fff, 16'sh7fff);
    send_frame(16'sh7fff, 16'sh7fff);
    wait_drained();
  endtask

  // Random frames over phases with fresh settings and idling on or off
  task automatic test_random_frames();
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      gaps_on   = (ph % 3) != 0;
      stalls_on = (ph % 4) != 1;
      if ($urandom_range(0, 3) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
                  s21u_pkg::CFG_DATA_W'($urandom()), 1'b1);
      if (ph == 0)
        configure(1'b0, s21u_pkg::CFG_DATA_W'($urandom()));
      else
        configure(ph != 3, pick_alpha());
      left  = pick_sample();
      right = pick_sample();
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        // Hold the input for a while now and then to see the step response
        if ($urandom_range(0, 3) != 0) begin
          left  = pick_sample();
          right = pick_sample();
        end
        send_frame(left, right);
        if (n == PHASE_FRAMES / 2 && ph == 2)
          wait_drained();
      end
      wait_drained();
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_passthrough();
    stalls_on = 1'b1;
    test_alpha_one();
    test_alpha_above_one();
    gaps_on = 1'b1;
    test_alpha_zero();
    test_unused_index();
    test_alpha_min();
    test_random_frames();
    wait_drained();
    if (mismatch_count == 0 && upmix_expected.size() == 0)
      $display("tb_stereo_to_2_1_upmix_lowpass_core passed");
    else
      $display("tb_stereo_to_2_1_upmix_lowpass_core failed");
    $finish;
  end

endmodule
